>>> design/kdop_pkg.sv
// Package for the k-DOP interval accumulator.
// Holds item kinds, sequencer states, the control bundle and fixed-point constants.
// Used by the top level and the sequencer; depends on nothing.
package kdop_pkg;

	localparam int PROJ_W  = 34;
	localparam int WIDTH_W = 35;
	localparam int DIR_W   = 16;

	localparam logic signed [PROJ_W-1:0] PROJ_MAX  = {1'b0, {(PROJ_W-1){1'b1}}};
	localparam logic signed [PROJ_W-1:0] PROJ_MIN  = {1'b1, {(PROJ_W-1){1'b0}}};
	localparam logic [WIDTH_W-1:0]       WIDTH_SAT = {WIDTH_W{1'b1}};

	typedef enum logic [1:0] {
		KIND_LOAD  = 2'd0,
		KIND_ADD   = 2'd1,
		KIND_JOIN  = 2'd2,
		KIND_CLEAR = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		LANE_X = 2'd0,
		LANE_Y = 2'd1,
		LANE_Z = 2'd2
	} lane_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_CLEAR,
		ST_JOIN_RD,
		ST_JOIN_UPD,
		ST_ADD_RD,
		ST_MUL_X,
		ST_MUL_Y,
		ST_MUL_Z,
		ST_ADD_UPD,
		ST_SCAN,
		ST_DRAIN1,
		ST_DRAIN2,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic  dir_we;
		logic  dir_re;
		logic  iv_re;
		logic  iv_we;
		logic  use_idx;
		logic  mac_en;
		logic  mac_first;
		lane_t lane;
		logic  join_sel;
		logic  clr_valid;
		logic  scan_issue;
		logic  scan_start;
		logic  out_load;
	} ctl_t;

endpackage

>>> design/kdop_interval_accumulator.sv
// Top level of the k-DOP interval accumulator: item registers, tables, interval update,
// width scan and the result register. Depends on kdop_pkg, kdop_ram, kdop_mac, kdop_ctrl.
//
//   channel | direction | handshake          | payload
//   s       | in        | s_tvalid/s_tready  | s_tuser: kind; s_tdata: index, x, y, z, join
//   m       | out       | m_tvalid/m_tready  | m_tdata: width, empty_res
//
// An add vertex item walks every direction through a read, multiply-accumulate steps for
// x, y and z on the shared unit and an interval update, then the width scan reads the
// interval memory one slot per cycle. Other items also end with the width scan. Reset
// empties every interval at once through per-slot valid bits. A stalled result waits in
// the output register while the next item is taken.
module kdop_interval_accumulator import kdop_pkg::*; #(
	parameter int DIRECTIONS = 16,
	parameter int COORD_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [1:0]   s_tuser,  // kind
	input  logic [119:0] s_tdata,  // index, x, y, z, join_low, join_high
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [39:0]  m_tdata   // width, empty_res, zero fill
);

	localparam int AW    = $clog2(DIRECTIONS);
	localparam int IXW   = (AW > 4) ? AW : 4;
	localparam int RW    = (COORD_BITS > 16) ? COORD_BITS : 16;
	localparam int ACC_W = COORD_BITS + DIR_W + 2;
	localparam int EXT_W = (ACC_W > PROJ_W + 1) ? ACC_W : PROJ_W + 1;
	localparam int IV_W  = 2 * PROJ_W;

	ctl_t          ctl;
	logic [AW-1:0] cnt;
	logic          accept;
	logic          in_idx_ok;
	logic          out_free;

	logic [3:0]                idx_q;
	logic [15:0]               x_q;
	logic [15:0]               y_q;
	logic [15:0]               z_q;
	logic signed [PROJ_W-1:0]  jl_q;
	logic signed [PROJ_W-1:0]  jh_q;

	logic [IXW-1:0]            idx_wide;
	logic [AW-1:0]             idx_addr;
	logic [AW-1:0]             dir_addr;
	logic [AW-1:0]             iv_addr;
	logic [3*DIR_W-1:0]        dir_rdata;
	logic [IV_W-1:0]           iv_rdata;
	logic [IV_W-1:0]           iv_wdata;
	logic [DIRECTIONS-1:0]     iv_valid_q;

	logic [RW-1:0]                 raw_sel;
	logic signed [COORD_BITS-1:0]  mac_a;
	logic signed [DIR_W-1:0]       mac_b;
	logic signed [ACC_W-1:0]       acc;
	logic signed [EXT_W-1:0]       acc_e;
	logic signed [PROJ_W-1:0]      proj;

	logic signed [PROJ_W-1:0]  cur_lo;
	logic signed [PROJ_W-1:0]  cur_hi;
	logic signed [PROJ_W-1:0]  cand_lo;
	logic signed [PROJ_W-1:0]  cand_hi;
	logic signed [PROJ_W-1:0]  new_lo;
	logic signed [PROJ_W-1:0]  new_hi;

	logic                      scan_v_s1;
	logic [AW-1:0]             addr_s1;
	logic signed [PROJ_W-1:0]  lo_s1;
	logic signed [PROJ_W-1:0]  hi_s1;
	logic signed [WIDTH_W-1:0] diff_s1;
	logic                      v_s2;
	logic signed [WIDTH_W-1:0] d_s2;
	logic [WIDTH_W:0]          triple_s2;
	logic [WIDTH_W-1:0]        w_s2;
	logic                      empty_s2;
	logic [WIDTH_W-1:0]        best_q;
	logic                      any_empty_q;

	logic                      m_tvalid_q;
	logic [39:0]               m_tdata_q;

	assign accept    = s_tvalid && s_tready;
	assign in_idx_ok = ({3'b000, s_tdata[3:0]} < 7'(DIRECTIONS));
	assign out_free  = !m_tvalid_q || m_tready;

	kdop_ctrl #(
		.DIRECTIONS(DIRECTIONS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_kind  (kind_t'(s_tuser)),
		.in_idx_ok(in_idx_ok),
		.out_free (out_free),
		.in_ready (s_tready),
		.cnt      (cnt),
		.ctl      (ctl)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q <= s_tdata[3:0];
			x_q   <= s_tdata[19:4];
			y_q   <= s_tdata[35:20];
			z_q   <= s_tdata[51:36];
			jl_q  <= s_tdata[85:52];
			jh_q  <= s_tdata[119:86];
		end
	end

	assign idx_wide = IXW'(idx_q);
	assign idx_addr = idx_wide[AW-1:0];
	assign dir_addr = ctl.dir_we ? idx_addr : cnt;
	assign iv_addr  = ctl.use_idx ? idx_addr : cnt;

	kdop_ram #(
		.W    (3 * DIR_W),
		.DEPTH(DIRECTIONS)
	) u_dir_ram (
		.clk  (clk),
		.we   (ctl.dir_we),
		.waddr(dir_addr),
		.wdata({z_q, y_q, x_q}),
		.re   (ctl.dir_re),
		.raddr(dir_addr),
		.rdata(dir_rdata)
	);

	kdop_ram #(
		.W    (IV_W),
		.DEPTH(DIRECTIONS)
	) u_iv_ram (
		.clk  (clk),
		.we   (ctl.iv_we),
		.waddr(iv_addr),
		.wdata(iv_wdata),
		.re   (ctl.iv_re),
		.raddr(iv_addr),
		.rdata(iv_rdata)
	);

	always_comb begin
		case (ctl.lane)
			LANE_X:  begin raw_sel = RW'(x_q); mac_b = dir_rdata[15:0];  end
			LANE_Y:  begin raw_sel = RW'(y_q); mac_b = dir_rdata[31:16]; end
			LANE_Z:  begin raw_sel = RW'(z_q); mac_b = dir_rdata[47:32]; end
			default: begin raw_sel = '0;       mac_b = '0;               end
		endcase
	end

	assign mac_a = raw_sel[COORD_BITS-1:0];

	kdop_mac #(
		.A_W  (COORD_BITS),
		.B_W  (DIR_W),
		.ACC_W(ACC_W)
	) u_mac (
		.clk  (clk),
		.en   (ctl.mac_en),
		.first(ctl.mac_first),
		.a    (mac_a),
		.b    (mac_b),
		.acc  (acc)
	);

	assign acc_e = EXT_W'(acc);

	always_comb begin
		if (acc_e > EXT_W'(PROJ_MAX)) begin
			proj = PROJ_MAX;
		end else if (acc_e < EXT_W'(PROJ_MIN)) begin
			proj = PROJ_MIN;
		end else begin
			proj = acc_e[PROJ_W-1:0];
		end
	end

	// A slot that was never written since the last clear reads as an empty interval.
	assign cur_lo  = iv_valid_q[iv_addr] ? iv_rdata[PROJ_W-1:0] : PROJ_MAX;
	assign cur_hi  = iv_valid_q[iv_addr] ? iv_rdata[IV_W-1:PROJ_W] : PROJ_MIN;
	assign cand_lo = ctl.join_sel ? jl_q : proj;
	assign cand_hi = ctl.join_sel ? jh_q : proj;
	assign new_lo  = (cand_lo < cur_lo) ? cand_lo : cur_lo;
	assign new_hi  = (cand_hi > cur_hi) ? cand_hi : cur_hi;
	assign iv_wdata = {new_hi, new_lo};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iv_valid_q <= '0;
		end else if (ctl.clr_valid) begin
			iv_valid_q <= '0;
		end else if (ctl.iv_we) begin
			iv_valid_q[iv_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_v_s1 <= 1'b0;
			v_s2      <= 1'b0;
		end else begin
			scan_v_s1 <= ctl.scan_issue;
			v_s2      <= scan_v_s1;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= cnt;
	end

	assign lo_s1   = iv_valid_q[addr_s1] ? iv_rdata[PROJ_W-1:0] : PROJ_MAX;
	assign hi_s1   = iv_valid_q[addr_s1] ? iv_rdata[IV_W-1:PROJ_W] : PROJ_MIN;
	assign diff_s1 = WIDTH_W'(hi_s1) - WIDTH_W'(lo_s1);

	always_ff @(posedge clk) begin
		if (scan_v_s1) begin
			d_s2 <= diff_s1;
		end
	end

	assign empty_s2  = d_s2[WIDTH_W-1];
	assign triple_s2 = {1'b0, d_s2} + {d_s2, 1'b0};
	assign w_s2      = WIDTH_W'(triple_s2 >> 2);

	always_ff @(posedge clk) begin
		if (ctl.scan_start) begin
			best_q      <= WIDTH_SAT;
			any_empty_q <= 1'b0;
		end else if (v_s2) begin
			if (empty_s2) begin
				any_empty_q <= 1'b1;
			end else if (w_s2 < best_q) begin
				best_q <= w_s2;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (ctl.out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			m_tdata_q <= {4'b0000, any_empty_q, best_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

>>> design/kdop_ram.sv
// Generic single-write, single-read memory with a registered read port.
// Stores the direction table and the interval table; depends on nothing.
module kdop_ram #(
	parameter int W     = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);

	logic [W-1:0] mem_q [DEPTH];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> design/kdop_mac.sv
// Shared multiply-accumulate unit that builds one projection as a sum of products.
// Signed operands, one product per cycle while en is high; depends on nothing.
module kdop_mac #(
	parameter int A_W   = 16,
	parameter int B_W   = 16,
	parameter int ACC_W = 34
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic                    first,
	input  logic signed [A_W-1:0]   a,
	input  logic signed [B_W-1:0]   b,
	output logic signed [ACC_W-1:0] acc
);

	logic signed [A_W+B_W-1:0] prod;
	logic signed [ACC_W-1:0]   acc_q;

	assign prod = a * b;

	always_ff @(posedge clk) begin
		if (en) begin
			acc_q <= (first ? '0 : acc_q) + ACC_W'(prod);
		end
	end

	assign acc = acc_q;

endmodule

>>> design/kdop_ctrl.sv
// Sequencer of the k-DOP interval accumulator: walks the directions for each item.
// Drives the control bundle and the slot counter; depends on kdop_pkg.
module kdop_ctrl import kdop_pkg::*; #(
	parameter int DIRECTIONS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  kind_t                         in_kind,
	input  logic                          in_idx_ok,
	input  logic                          out_free,
	output logic                          in_ready,
	output logic [$clog2(DIRECTIONS)-1:0] cnt,
	output ctl_t                          ctl
);

	localparam int AW = $clog2(DIRECTIONS);

	state_t        state_q;
	state_t        state_d;
	logic [AW-1:0] cnt_q;
	logic          last;

	assign last = (cnt_q == AW'(DIRECTIONS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_ADD_UPD || state_q == ST_SCAN) begin
				cnt_q <= last ? '0 : cnt_q + AW'(1);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (in_kind)
						KIND_LOAD:  state_d = in_idx_ok ? ST_LOAD : ST_SCAN;
						KIND_ADD:   state_d = ST_ADD_RD;
						KIND_JOIN:  state_d = in_idx_ok ? ST_JOIN_RD : ST_SCAN;
						KIND_CLEAR: state_d = ST_CLEAR;
						default:    state_d = ST_SCAN;
					endcase
				end
			end
			ST_LOAD:     state_d = ST_SCAN;
			ST_CLEAR:    state_d = ST_SCAN;
			ST_JOIN_RD:  state_d = ST_JOIN_UPD;
			ST_JOIN_UPD: state_d = ST_SCAN;
			ST_ADD_RD:   state_d = ST_MUL_X;
			ST_MUL_X:    state_d = ST_MUL_Y;
			ST_MUL_Y:    state_d = ST_MUL_Z;
			ST_MUL_Z:    state_d = ST_ADD_UPD;
			ST_ADD_UPD:  state_d = last ? ST_SCAN : ST_ADD_RD;
			ST_SCAN:     state_d = last ? ST_DRAIN1 : ST_SCAN;
			ST_DRAIN1:   state_d = ST_DRAIN2;
			ST_DRAIN2:   state_d = ST_OUT;
			ST_OUT:      state_d = out_free ? ST_IDLE : ST_OUT;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl      = '0;
		ctl.lane = LANE_X;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_LOAD: begin
				ctl.dir_we = 1'b1;
			end
			ST_CLEAR: begin
				ctl.clr_valid = 1'b1;
			end
			ST_JOIN_RD: begin
				ctl.iv_re   = 1'b1;
				ctl.use_idx = 1'b1;
			end
			ST_JOIN_UPD: begin
				ctl.iv_we    = 1'b1;
				ctl.use_idx  = 1'b1;
				ctl.join_sel = 1'b1;
			end
			ST_ADD_RD: begin
				ctl.dir_re = 1'b1;
				ctl.iv_re  = 1'b1;
			end
			ST_MUL_X: begin
				ctl.mac_en    = 1'b1;
				ctl.mac_first = 1'b1;
				ctl.lane      = LANE_X;
			end
			ST_MUL_Y: begin
				ctl.mac_en = 1'b1;
				ctl.lane   = LANE_Y;
			end
			ST_MUL_Z: begin
				ctl.mac_en = 1'b1;
				ctl.lane   = LANE_Z;
			end
			ST_ADD_UPD: begin
				ctl.iv_we = 1'b1;
			end
			ST_SCAN: begin
				ctl.iv_re      = 1'b1;
				ctl.scan_issue = 1'b1;
				ctl.scan_start = (cnt_q == '0);
			end
			ST_DRAIN1: begin
			end
			ST_DRAIN2: begin
			end
			ST_OUT: begin
				ctl.out_load = out_free;
			end
			default: begin
			end
		endcase
	end

	assign cnt = cnt_q;

endmodule

>>> tb/kdop_hull_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the k-DOP interval accumulator: watches both stream channels, predicts
// the smallest scaled interval width and the empty flag for every item, and compares.
// Depends on kdop_pkg.
module kdop_hull_checker import kdop_pkg::*; #(
	parameter int SLOTS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [1:0]   s_tuser,  // kind
	input  logic [119:0] s_tdata,  // index, x, y, z, join_low, join_high
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [39:0]  m_tdata,  // width, empty_res, zero fill
	output int           mismatches,
	output int           outstanding
);

	typedef struct packed {
		logic [WIDTH_W-1:0] width;
		logic               empty;
	} hull_report_t;

	logic signed [DIR_W-1:0]  dir_x [SLOTS];
	logic signed [DIR_W-1:0]  dir_y [SLOTS];
	logic signed [DIR_W-1:0]  dir_z [SLOTS];
	logic signed [PROJ_W-1:0] iv_low [SLOTS];
	logic signed [PROJ_W-1:0] iv_high [SLOTS];
	hull_report_t             pending_reports [$];
	int                       result_no = 0;

	function automatic void empty_intervals();
		for (int j = 0; j < SLOTS; j++) begin
			iv_low[j]  = PROJ_MAX;
			iv_high[j] = PROJ_MIN;
		end
	endfunction

	function automatic hull_report_t advance_hull(input kind_t kind, input logic [119:0] d);
		hull_report_t rep;
		int           slot;
		longint       vx, vy, vz, proj, jlo, jhi, span, w;
		slot = int'(d[3:0]);
		vx   = longint'($signed(d[19:4]));
		vy   = longint'($signed(d[35:20]));
		vz   = longint'($signed(d[51:36]));
		jlo  = longint'($signed(d[85:52]));
		jhi  = longint'($signed(d[119:86]));
		case (kind)
			KIND_LOAD: begin
				if (slot < SLOTS) begin
					dir_x[slot] = d[19:4];
					dir_y[slot] = d[35:20];
					dir_z[slot] = d[51:36];
				end
			end
			KIND_ADD: begin
				for (int j = 0; j < SLOTS; j++) begin
					proj = vx * dir_x[j] + vy * dir_y[j] + vz * dir_z[j];
					if (proj > longint'(PROJ_MAX))
						proj = longint'(PROJ_MAX);
					if (proj < longint'(PROJ_MIN))
						proj = longint'(PROJ_MIN);
					if (proj < iv_low[j])
						iv_low[j] = proj[PROJ_W-1:0];
					if (proj > iv_high[j])
						iv_high[j] = proj[PROJ_W-1:0];
				end
			end
			KIND_JOIN: begin
				if (slot < SLOTS) begin
					if (jlo < iv_low[slot])
						iv_low[slot] = jlo[PROJ_W-1:0];
					if (jhi > iv_high[slot])
						iv_high[slot] = jhi[PROJ_W-1:0];
				end
			end
			KIND_CLEAR: begin
				empty_intervals();
			end
			default: ;
		endcase
		rep.width = WIDTH_SAT;
		rep.empty = 1'b0;
		for (int j = 0; j < SLOTS; j++) begin
			if (iv_low[j] > iv_high[j]) begin
				rep.empty = 1'b1;
			end else begin
				span = longint'(iv_high[j]) - longint'(iv_low[j]);
				w    = (span * 3) >>> 2;
				if (w > longint'(WIDTH_SAT))
					w = longint'(WIDTH_SAT);
				if (w < rep.width)
					rep.width = w[WIDTH_W-1:0];
			end
		end
		return rep;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < SLOTS; j++) begin
				dir_x[j] = '0;
				dir_y[j] = '0;
				dir_z[j] = '0;
			end
			empty_intervals();
			pending_reports.delete();
			outstanding = 0;
			mismatches  = 0;
		end else begin : watch
			hull_report_t       want;
			logic [WIDTH_W-1:0] got_width;
			logic               got_empty;
			if (m_tvalid && m_tready) begin
				got_width = m_tdata[WIDTH_W-1:0];
				got_empty = m_tdata[WIDTH_W];
				if (pending_reports.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d arrived with no item pending: %s %0d empty %0b",
							result_no, "width", got_width, got_empty);
				end else begin
					want = pending_reports.pop_front();
					if (got_width !== want.width || got_empty !== want.empty) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"result %0d: expected width %0d empty %0b,",
								" got width %0d empty %0b"},
								result_no, want.width, want.empty, got_width, got_empty);
					end
				end
				result_no++;
			end
			if (s_tvalid && s_tready)
				pending_reports = {pending_reports, advance_hull(kind_t'(s_tuser), s_tdata)};
			outstanding = pending_reports.size();
		end
	end

endmodule

>>> tb/tb_kdop_interval_accumulator.sv
`timescale 1ns / 1ps
// Testbench top for the k-DOP interval accumulator: clock, reset, item stimulus with
// random gaps and stalls, and the verdict. Depends on kdop_pkg and kdop_hull_checker.
module tb_kdop_interval_accumulator;
	import kdop_pkg::*;

	localparam int PERIOD       = 20;
	localparam int RANDOM_ITEMS = 725;
	localparam int CYCLE_LIMIT  = 600000;

	logic         clk = 1'b0;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [1:0]   s_tuser;
	logic [119:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [39:0]  m_tdata;
	int           mismatches;
	int           outstanding;
	int           cycles = 0;
	logic         src_calm = 1'b0;

	always #(PERIOD / 2) clk = ~clk;

	kdop_interval_accumulator uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	kdop_hull_checker hull_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tuser     (s_tuser),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic logic [15:0] rand_coord();
		logic [15:0] v;
		v = 16'($urandom());
		case ($urandom_range(0, 7))
			0: v = 16'h8000;
			1: v = 16'h7FFF;
			2: v = {{8{v[7]}}, v[7:0]};
			default: ;
		endcase
		return v;
	endfunction

	function automatic logic [33:0] rand_proj();
		logic [33:0] v;
		v[31:0]  = $urandom();
		v[33:32] = 2'($urandom_range(0, 3));
		case ($urandom_range(0, 7))
			0: v = PROJ_MAX;
			1: v = PROJ_MIN;
			2, 3: v = {{4{v[29]}}, v[29:0]};
			default: ;
		endcase
		return v;
	endfunction

	task automatic offer_item(input kind_t kind, input logic [3:0] slot,
			input logic [15:0] px, input logic [15:0] py, input logic [15:0] pz,
			input logic [33:0] jlo, input logic [33:0] jhi);
		int gap;
		gap = src_calm ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tuser  <= kind;
		s_tdata  <= {jhi, jlo, pz, py, px, slot};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!(s_tvalid && s_tready));
	endtask

	initial begin : sink
		int   gap;
		int   taken;
		logic calm;
		taken = 0;
		calm  = 1'b0;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (taken % 50 == 0)
				calm = ($urandom_range(0, 2) == 0);
			gap = calm ? 0 : $urandom_range(0, 17);
			// One long hold-off so the result register fills and the input backs up.
			if (taken == 120)
				gap = 700;
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
			taken++;
		end
	end

	initial begin : source
		logic [3:0]  slot;
		logic [33:0] jlo;
		logic [33:0] jhi;
		kind_t       kind;
		int          pick;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tuser  <= KIND_LOAD;
		s_tdata  <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// All slots empty, then an inverted join and a full-range join on empty slots.
		offer_item(KIND_CLEAR, 4'd0, 16'd0, 16'd0, 16'd0, 34'd0, 34'd0);
		offer_item(KIND_JOIN, 4'd0, 16'd0, 16'd0, 16'd0, 34'd1000, -34'sd1000);
		offer_item(KIND_JOIN, 4'd15, 16'd0, 16'd0, 16'd0, PROJ_MIN, PROJ_MAX);
		// Every direction is loaded before the first vertex goes in.
		for (int j = 0; j < 16; j++) begin
			slot = 4'(j);
			offer_item(KIND_LOAD, slot, slot[0] ? 16'h7FFF : 16'h8000,
				slot[1] ? 16'h7FFF : 16'h8000, slot[2] ? 16'h4000 : 16'hC000,
				34'd0, 34'd0);
		end
		offer_item(KIND_ADD, 4'd0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 34'd0, 34'd0);
		offer_item(KIND_ADD, 4'd0, 16'h8000, 16'h8000, 16'h8000, 34'd0, 34'd0);
		offer_item(KIND_JOIN, 4'd7, 16'd0, 16'd0, 16'd0, PROJ_MIN, PROJ_MAX);
		offer_item(KIND_CLEAR, 4'd0, 16'd0, 16'd0, 16'd0, 34'd0, 34'd0);
		offer_item(KIND_ADD, 4'd0, 16'h8000, 16'h7FFF, 16'h0000, 34'd0, 34'd0);
		offer_item(KIND_JOIN, 4'd3, 16'd0, 16'd0, 16'd0, PROJ_MAX, PROJ_MIN);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 60 == 0)
				src_calm = ($urandom_range(0, 2) == 0);
			pick = $urandom_range(0, 99);
			jlo  = rand_proj();
			if ($urandom_range(0, 2) != 0)
				jhi = jlo + 34'($urandom_range(0, 1 << 20));
			else
				jhi = rand_proj();
			if (pick < 8)
				kind = KIND_CLEAR;
			else if (pick < 22)
				kind = KIND_LOAD;
			else if (pick < 45)
				kind = KIND_JOIN;
			else
				kind = KIND_ADD;
			slot = 4'($urandom_range(0, 15));
			offer_item(kind, slot, rand_coord(), rand_coord(), rand_coord(), jlo, jhi);
		end
		s_tvalid <= 1'b0;

		do @(posedge clk); while (outstanding != 0);
		repeat (120) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

>>> sim.f
design/kdop_pkg.sv
design/kdop_ram.sv
design/kdop_mac.sv
design/kdop_ctrl.sv
design/kdop_interval_accumulator.sv
tb/kdop_hull_checker.sv
tb/tb_kdop_interval_accumulator.sv
